@@ rtl/fixed_point_alu_q24_8_top_assert.svh @@
// Assertion macros for the Q24.8 fixed-point ALU.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/fpalu_pkg.sv @@
// Package for the Q24.8 fixed-point ALU: word/fraction widths, opcodes.
// No dependencies.
`timescale 1ns / 1ps

package fpalu_pkg;

  localparam int WordBits    = 32;
  localparam int FracBits    = 8;
  // Dividend is |a| shifted left by the fraction width
  localparam int NumBits     = WordBits + FracBits;
  // Quotient bits resolved per divider stage
  localparam int DivPerStage = 4;
  localparam int DivStages   = (NumBits + DivPerStage - 1) / DivPerStage;
  localparam int ProdBits    = 2 * WordBits;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_EQ       = 4'd4,
    OP_NE       = 4'd5,
    OP_GT       = 4'd6,
    OP_LT       = 4'd7,
    OP_LE       = 4'd8,
    OP_GE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_e;

  // Per-stage pipeline payload
  typedef struct packed {
    op_e                   op;
    logic [WordBits-1:0]   res;   // result of the ops other than mul/div
    logic                  cmp;
    logic                  dz;
    logic                  neg;   // sign of the exact mul/div result
    logic [WordBits-1:0]   d;     // |b|
    logic [NumBits-1:0]    num;   // dividend bits, consumed MSB first
    logic [WordBits-1:0]   rem;   // partial remainder
    logic [NumBits-1:0]    q;     // quotient bits
    logic [ProdBits-1:0]   prod;  // |a| * |b|
  } stage_t;

endpackage

@@ rtl/fixed_point_alu_q24_8_top.sv @@
// Top level of the Q24.8 fixed-point ALU: decode, pipelined divider and
// multiplier, round/saturate output stage. Uses fpalu_pkg and the assert header.
`timescale 1ns / 1ps
`include "fixed_point_alu_q24_8_top_assert.svh"

// Usage
// - Input channel (in_valid_i/in_ready_o) carries op_i, operand_a_i, operand_b_i.
// - Output channel (out_valid_o/out_ready_i) carries result_o, compare_true_o,
//   divide_by_zero_o; exactly one result transaction per input transaction.
// - Every op takes the same path: one decode stage, DivStages (10) divider
//   stages of four quotient bits each, and one round/saturate output register.
// - Throughput is one transaction per cycle unless the receiver stalls; the
//   restoring divider is fully unrolled across its stages, and the multiply
//   sits in the first of them.
// - The whole pipeline advances together whenever the output register is empty
//   or being taken; when the receiver stalls with a result waiting, in_ready_o
//   drops and every stage holds, so nothing is lost or repeated.
// - Reset clears all valid bits; no transaction is in flight afterwards and the
//   block accepts input in the first cycle after reset is released.
// - Mul and div round half away from zero and saturate; add, sub, inc, dec and
//   the shifts wrap. Divide by zero returns zero with divide_by_zero_o set.
module fixed_point_alu_q24_8_top
  import fpalu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3:0]          op_i,
  input  logic signed [31:0]  operand_a_i,
  input  logic signed [31:0]  operand_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  result_o,
  output logic                compare_true_o,
  output logic                divide_by_zero_o
);

  // Four restoring-division steps
  function automatic stage_t div_step(stage_t s);
    stage_t            r;
    logic [WordBits:0] t;
    r = s;
    for (int i = 0; i < DivPerStage; i++) begin
      t     = {r.rem, r.num[NumBits-1]};
      r.num = {r.num[NumBits-2:0], 1'b0};
      if (t >= {1'b0, r.d}) begin
        t   = t - {1'b0, r.d};
        r.q = {r.q[NumBits-2:0], 1'b1};
      end else begin
        r.q = {r.q[NumBits-2:0], 1'b0};
      end
      r.rem = t[WordBits-1:0];
    end
    return r;
  endfunction

  // Clamp a magnitude to the signed word range and apply the sign
  function automatic logic [WordBits-1:0] sat_sign(logic [ProdBits-1:0] mag, logic neg);
    logic [WordBits-1:0] lim;
    logic [WordBits-1:0] m;
    lim = neg ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
    m   = (mag > {{(ProdBits-WordBits){1'b0}}, lim}) ? lim : mag[WordBits-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

  localparam logic [ProdBits-1:0] Half = ProdBits'(1) << (FracBits - 1);

  logic                 adv;
  logic [DivStages:0]   vld_q;
  stage_t               st_q [DivStages+1];
  stage_t               st_d [DivStages+1];
  logic                 out_valid_q;
  logic [WordBits-1:0]  res_q, res_d;
  logic                 cmp_q, dz_q;

  // Pipeline advances when the output register is free or drained
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Decode stage: results of all ops but mul/div, magnitudes, sign
  logic [WordBits-1:0] a_u, b_u, ma, mb;
  logic                lt, gt;
  op_e                 op_in;

  always_comb begin
    a_u   = operand_a_i;
    b_u   = operand_b_i;
    op_in = op_e'(op_i);
    ma    = a_u[WordBits-1] ? (~a_u + 1'b1) : a_u;
    mb    = b_u[WordBits-1] ? (~b_u + 1'b1) : b_u;
    lt    = operand_a_i < operand_b_i;
    gt    = operand_b_i < operand_a_i;

    st_d[0]      = '0;
    st_d[0].op   = op_in;
    st_d[0].neg  = a_u[WordBits-1] ^ b_u[WordBits-1];
    st_d[0].d    = mb;
    st_d[0].num  = {ma, {FracBits{1'b0}}};
    st_d[0].dz   = (op_in == OP_DIV) && (b_u == '0);
    case (op_in)
      OP_ADD:      st_d[0].res = a_u + b_u;
      OP_SUB:      st_d[0].res = a_u - b_u;
      OP_EQ:       st_d[0].cmp = (a_u == b_u);
      OP_NE:       st_d[0].cmp = (a_u != b_u);
      OP_GT:       st_d[0].cmp = gt;
      OP_LT:       st_d[0].cmp = lt;
      OP_LE:       st_d[0].cmp = !gt;
      OP_GE:       st_d[0].cmp = !lt;
      OP_MIN:      st_d[0].res = lt ? a_u : b_u;
      OP_MAX:      st_d[0].res = gt ? a_u : b_u;
      OP_INC:      st_d[0].res = a_u + 1'b1;
      OP_DEC:      st_d[0].res = a_u - 1'b1;
      OP_TO_INT:   st_d[0].res = WordBits'(operand_a_i >>> FracBits);
      OP_FROM_INT: st_d[0].res = a_u << FracBits;
      default:     st_d[0].res = '0;
    endcase

    // Divider stages; the multiply rides in the first one
    for (int k = 1; k <= DivStages; k++) begin
      st_d[k] = div_step(st_q[k-1]);
    end
    st_d[1].prod = ProdBits'(st_q[0].num[NumBits-1:FracBits]) * ProdBits'(st_q[0].d);
  end

  // Output stage: round and saturate mul/div, select result
  logic [ProdBits-1:0] mul_rnd;
  logic [ProdBits-1:0] div_rnd;
  logic                div_up;
  stage_t              fin;

  always_comb begin
    fin     = st_q[DivStages];
    mul_rnd = (fin.prod + Half) >> FracBits;
    div_up  = fin.rem >= (fin.d - fin.rem);
    div_rnd = ProdBits'(fin.q) + ProdBits'(div_up);
    case (fin.op)
      OP_MUL:  res_d = sat_sign(mul_rnd, fin.neg);
      OP_DIV:  res_d = fin.dz ? '0 : sat_sign(div_rnd, fin.neg);
      default: res_d = fin.res;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[DivStages-1:0], in_valid_i};
      out_valid_q <= vld_q[DivStages];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= DivStages; k++) begin
        st_q[k] <= st_d[k];
      end
      res_q <= res_d;
      cmp_q <= fin.cmp;
      dz_q  <= fin.dz;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = res_q;
  assign compare_true_o   = cmp_q;
  assign divide_by_zero_o = dz_q;

  // Checks
  `FPA_ASSERT(a_cmp_zero_res, clk_i, rst_ni, out_valid_o && compare_true_o |-> result_o == '0, "compare with nonzero result")
  `FPA_ASSERT(a_dz_clean, clk_i, rst_ni, out_valid_o && divide_by_zero_o |-> result_o == '0 && !compare_true_o, "divide by zero with result")
  `FPA_ASSERT(a_accept_enters, clk_i, rst_ni, in_valid_i && in_ready_o |=> vld_q[0], "accepted transaction not in pipe")
  `FPA_ASSERT(a_stall_holds, clk_i, rst_ni, !in_ready_o |=> $stable(vld_q), "pipe moved during stall")
  `FPA_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> vld_q == '0 && !out_valid_o, "pipe not empty in reset")

endmodule
